@@ design/terminal_escape_key_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// Terminal escape key decoder: assertion macros
// Shared property wrappers for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_KEY_DECODER_CORE_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TEKD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TEKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tekd_pkg.sv @@
// ----------------------------------------------------------------------------
// tekd_pkg
// Types, byte codes and key codes shared by the terminal key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tekd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned SEQ_DEPTH = 4;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned OUT_W     = 16;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Register index of the only configuration register.
  localparam logic [0:0] REG_ESCAPE_MEANS_QUIT = 1'b0;

  localparam byte_t ESC_BYTE   = 8'd27;
  localparam byte_t CTRL_MASK  = 8'h1f;
  localparam byte_t CH_P       = 8'h50;
  localparam byte_t PRINT_BYTE = CH_P & CTRL_MASK;
  localparam byte_t CH_TILDE   = 8'h7e;
  localparam byte_t CH_O       = 8'h4f;
  localparam byte_t CH_BRACKET = 8'h5b;
  localparam byte_t CH_S       = 8'h53;
  localparam byte_t CH_A       = 8'h41;
  localparam byte_t CH_B       = 8'h42;
  localparam byte_t CH_C       = 8'h43;
  localparam byte_t CH_D       = 8'h44;
  localparam byte_t CH_E       = 8'h45;
  localparam byte_t CH_F       = 8'h46;
  localparam byte_t CH_H       = 8'h48;
  localparam byte_t CH_0       = 8'h30;
  localparam byte_t CH_1       = 8'h31;
  localparam byte_t CH_2       = 8'h32;
  localparam byte_t CH_3       = 8'h33;
  localparam byte_t CH_4       = 8'h34;
  localparam byte_t CH_5       = 8'h35;
  localparam byte_t CH_6       = 8'h36;
  localparam byte_t CH_7       = 8'h37;
  localparam byte_t CH_8       = 8'h38;
  localparam byte_t CH_9       = 8'h39;

  localparam key_t K_F1     = 5'd0;
  localparam key_t K_F5     = 5'd4;
  localparam key_t K_F6     = 5'd5;
  localparam key_t K_F9     = 5'd8;
  localparam key_t K_HOME   = 5'd12;
  localparam key_t K_END    = 5'd13;
  localparam key_t K_INSERT = 5'd14;
  localparam key_t K_DELETE = 5'd15;
  localparam key_t K_PGUP   = 5'd16;
  localparam key_t K_PGDN   = 5'd17;
  localparam key_t K_UP     = 5'd18;
  localparam key_t K_DOWN   = 5'd19;
  localparam key_t K_LEFT   = 5'd20;
  localparam key_t K_RIGHT  = 5'd21;
  localparam key_t K_PRINT  = 5'd22;
  localparam key_t K_ESCAPE = 5'd23;
  localparam key_t K_QUIT   = 5'd24;

  // One result item, in the order it is packed on the output bus.
  typedef struct packed {
    logic  seq_dropped;
    key_t  special_key;
    byte_t char_code;
    logic  is_special;
    logic  key_valid;
  } result_t;

endpackage

`default_nettype wire

@@ design/tekd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tekd_cfg_regs
// APB-style register file holding the escape-means-quit control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_cfg_regs
  import tekd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic                   escape_means_quit
);

  logic esc_quit_r;
  logic esc_quit_nxt;
  logic hit;

  // Register i sits at byte address 4*i; the word index is paddr[2].
  assign hit    = (paddr[CFG_AW-1] == REG_ESCAPE_MEANS_QUIT);
  assign pready = 1'b1;

  always_comb begin
    esc_quit_nxt = esc_quit_r;
    if (psel && penable && pwrite && pready && hit) begin
      esc_quit_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_quit_r <= 1'b0;
    end else begin
      esc_quit_r <= esc_quit_nxt;
    end
  end

  assign prdata            = hit ? {{(CFG_DW-1){1'b0}}, esc_quit_r} : '0;
  assign escape_means_quit = esc_quit_r;

endmodule

`default_nettype wire

@@ design/tekd_seq_engine.sv @@
// ----------------------------------------------------------------------------
// tekd_seq_engine
// Sequence state and the per-byte table match that produces one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tekd_seq_engine
  import tekd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  advance,
  input  wire byte_t cur_byte,
  input  wire logic  escape_means_quit,
  output result_t    result
);

  typedef struct packed {
    logic need;
    logic nomatch;
    key_t key;
  } dec_t;

  // Terminator check: undecided until the byte at pos has arrived.
  function automatic dec_t tilde_at(input count_t n, input count_t pos,
                                    input byte_t t, input key_t key);
    dec_t d;
    d = '{need: 1'b0, nomatch: 1'b0, key: key};
    if (n < pos + 3'd1) begin
      d.need = 1'b1;
    end else if (t != CH_TILDE) begin
      d.nomatch = 1'b1;
    end
    return d;
  endfunction

  // Digit 5/7/8/9 to offset 0..3; top bit flags a hit.
  function automatic logic [2:0] idx5789(input byte_t c);
    logic [2:0] r;
    unique case (c)
      CH_5:    r = 3'b100;
      CH_7:    r = 3'b101;
      CH_8:    r = 3'b110;
      CH_9:    r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // Digit 0/1/3/4 to offset 0..3; top bit flags a hit.
  function automatic logic [2:0] idx0134(input byte_t c);
    logic [2:0] r;
    unique case (c)
      CH_0:    r = 3'b100;
      CH_1:    r = 3'b101;
      CH_3:    r = 3'b110;
      CH_4:    r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic dec_t decode_seq(input count_t n, input byte_t b1, input byte_t b2,
                                      input byte_t b3, input byte_t b4);
    dec_t       d;
    dec_t       nm;
    logic [2:0] ix;
    byte_t      diff;
    nm   = '{need: 1'b0, nomatch: 1'b1, key: '0};
    d    = nm;
    ix   = '0;
    diff = '0;
    unique case (b1)
      CH_O: begin
        if (b2 >= CH_P && b2 <= CH_S) begin
          diff = b2 - CH_P;
          d = '{need: 1'b0, nomatch: 1'b0, key: K_F1 + {3'b000, diff[1:0]}};
        end
      end
      CH_1: begin
        ix = idx5789(b2);
        if (ix[2]) d = tilde_at(n, 3'd3, b3, K_F5 + {3'b000, ix[1:0]});
      end
      CH_2: begin
        ix = idx0134(b2);
        if (ix[2]) d = tilde_at(n, 3'd3, b3, K_F9 + {3'b000, ix[1:0]});
      end
      CH_BRACKET: begin
        unique case (b2)
          CH_1: begin
            if (n < 3'd4) begin
              d = '{need: 1'b1, nomatch: 1'b0, key: '0};
            end else if (b3 == CH_TILDE) begin
              d = '{need: 1'b0, nomatch: 1'b0, key: K_HOME};
            end else begin
              ix = idx5789(b3);
              if (ix[2]) d = tilde_at(n, 3'd4, b4, K_F5 + {3'b000, ix[1:0]});
            end
          end
          CH_2: begin
            if (n < 3'd4) begin
              d = '{need: 1'b1, nomatch: 1'b0, key: '0};
            end else if (b3 == CH_TILDE) begin
              d = '{need: 1'b0, nomatch: 1'b0, key: K_INSERT};
            end else begin
              ix = idx0134(b3);
              if (ix[2]) d = tilde_at(n, 3'd4, b4, K_F9 + {3'b000, ix[1:0]});
            end
          end
          CH_3: d = tilde_at(n, 3'd3, b3, K_DELETE);
          CH_4: d = tilde_at(n, 3'd3, b3, K_END);
          CH_5: d = tilde_at(n, 3'd3, b3, K_PGUP);
          CH_6: d = tilde_at(n, 3'd3, b3, K_PGDN);
          CH_A: d = '{need: 1'b0, nomatch: 1'b0, key: K_UP};
          CH_B: d = '{need: 1'b0, nomatch: 1'b0, key: K_DOWN};
          CH_C: d = '{need: 1'b0, nomatch: 1'b0, key: K_RIGHT};
          CH_D: d = '{need: 1'b0, nomatch: 1'b0, key: K_LEFT};
          CH_F: d = '{need: 1'b0, nomatch: 1'b0, key: K_END};
          CH_H: d = '{need: 1'b0, nomatch: 1'b0, key: K_HOME};
          CH_BRACKET: begin
            if (n < 3'd4) begin
              d = '{need: 1'b1, nomatch: 1'b0, key: '0};
            end else if (b3 >= CH_A && b3 <= CH_E) begin
              diff = b3 - CH_A;
              d = '{need: 1'b0, nomatch: 1'b0, key: K_F1 + diff[KEY_W-1:0]};
            end else if (b3 >= CH_7 && b3 <= CH_9) begin
              diff = b3 - CH_7;
              d = tilde_at(n, 3'd4, b4, K_F6 + diff[KEY_W-1:0]);
            end
          end
          default: d = nm;
        endcase
      end
      ESC_BYTE: begin
        if (b2 == ESC_BYTE) d = '{need: 1'b0, nomatch: 1'b0, key: K_ESCAPE};
      end
      default: d = nm;
    endcase
    return d;
  endfunction

  byte_t      seq_bytes_r [SEQ_DEPTH];
  count_t     seq_count_r;
  count_t     seq_count_nxt;
  byte_t      eff [SEQ_DEPTH];
  count_t     n;
  count_t     pos_full;
  logic [POS_W-1:0] pos;
  dec_t       dec;
  key_t       key;

  assign pos_full = seq_count_r - 3'd1;
  assign pos      = pos_full[POS_W-1:0];
  assign n        = seq_count_r + 3'd1;

  // The new byte overrides its slot so the match sees the whole sequence so far.
  always_comb begin
    for (int k = 0; k < SEQ_DEPTH; k++) begin
      eff[k] = seq_bytes_r[k];
    end
    eff[pos] = cur_byte;
  end

  always_comb begin
    dec           = decode_seq(n, eff[0], eff[1], eff[2], eff[3]);
    result        = '0;
    seq_count_nxt = seq_count_r;
    key           = dec.key;
    if (key == K_ESCAPE && escape_means_quit) begin
      key = K_QUIT;
    end
    if (seq_count_r == '0) begin
      if (cur_byte == ESC_BYTE) begin
        seq_count_nxt = 3'd1;
      end else if (cur_byte == PRINT_BYTE) begin
        result.key_valid   = 1'b1;
        result.is_special  = 1'b1;
        result.special_key = K_PRINT;
      end else begin
        result.key_valid = 1'b1;
        result.char_code = cur_byte;
      end
    end else if (n < 3'd3) begin
      seq_count_nxt = n;
    end else if (dec.need && n < 3'd5) begin
      seq_count_nxt = n;
    end else begin
      seq_count_nxt = '0;
      if (dec.need || dec.nomatch) begin
        result.seq_dropped = 1'b1;
      end else begin
        result.key_valid   = 1'b1;
        result.is_special  = 1'b1;
        result.special_key = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_count_r <= '0;
    end else if (advance) begin
      seq_count_r <= seq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && seq_count_r != '0) begin
      seq_bytes_r[pos] <= cur_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/terminal_escape_key_decoder_core.sv @@
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_core
// Decodes a terminal byte stream into plain characters and special keys.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is held in the input register, and its result then waits
//   in the result register, which drives out_tdata until the sink takes it.
// Throughput: one request per cycle while out_tready is high; the table match is one pass of logic.
// Reset: rst_n is synchronous and active low; it empties both pipeline registers,
//   clears the pending-sequence count and sets escape_means_quit to 0.
`default_nettype none

module terminal_escape_key_decoder_core
  import tekd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,    // [7:0] in_byte
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,   // [0] key_valid, [1] is_special,
                                              // [9:2] char_code, [14:10] special_key,
                                              // [15] seq_dropped
  // Configuration port.
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  logic    in_valid_r;
  byte_t   in_byte_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    escape_means_quit;
  result_t result;

  // The byte in the input register moves on whenever the result register is
  // free or is being emptied in this same cycle. The sequence state updates at
  // that edge too, so the following byte always sees the up-to-date state.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Result register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  tekd_cfg_regs u_cfg (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (cfg_psel),
    .penable           (cfg_penable),
    .pwrite            (cfg_pwrite),
    .paddr             (cfg_paddr),
    .pwdata            (cfg_pwdata),
    .prdata            (cfg_prdata),
    .pready            (cfg_pready),
    .escape_means_quit (escape_means_quit)
  );

  // Every byte gives exactly one result: a character, a key, a pending
  // marker (all zero) or a dropped-sequence flag.
  tekd_seq_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .cur_byte          (in_byte_r),
    .escape_means_quit (escape_means_quit),
    .result            (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

`default_nettype wire

@@ design/tekd_checker.sv @@
// ----------------------------------------------------------------------------
// tekd_checker
// Port-level checks on the result stream of the terminal key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "terminal_escape_key_decoder_core_defines.svh"

module tekd_checker
  import tekd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  `TEKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `TEKD_ASSERT_IMPL(a_key_or_drop, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[15]), "key reported on a dropped sequence")
  `TEKD_ASSERT_IMPL(a_special_fields, clk, rst_n, out_tvalid && out_tdata[1], out_tdata[0] && (out_tdata[9:2] == 8'd0) && (out_tdata[14:10] <= K_QUIT), "bad special key result")
  `TEKD_ASSERT_IMPL(a_plain_fields, clk, rst_n, out_tvalid && !out_tdata[1], out_tdata[14:10] == 5'd0, "key code set on a plain result")

endmodule

bind terminal_escape_key_decoder_core tekd_checker u_tekd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
